[src/pedr_pkg.sv]
// Shared types, constants and stick conditioning for the pad edge/repeat block.
`default_nettype none
package pedr_pkg;

  localparam int NUM_PADS_DEF = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_X_LIMIT         = 2'd0;
  localparam logic [1:0] CFG_Y_LIMIT         = 2'd1;
  localparam logic [1:0] CFG_INITIAL_DELAY   = 2'd2;
  localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd3;

  localparam logic [6:0] X_LIMIT_RST         = 7'h46;
  localparam logic [6:0] Y_LIMIT_RST         = 7'h46;
  localparam logic [7:0] INITIAL_DELAY_RST   = 8'h1E;
  localparam logic [7:0] REPEAT_INTERVAL_RST = 8'h0A;

  localparam logic [7:0] STATUS_NO_RESPONSE = 8'd8;
  localparam logic signed [8:0] DEAD_ZONE = 9'sd9;

  typedef struct packed {
    logic [6:0] x_limit;
    logic [6:0] y_limit;
    logic [7:0] initial_delay;
    logic [7:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic [15:0] prev_buttons;
    logic [7:0]  count;
  } pad_entry_t;

  // Dead zone, then clamp to +/- lim.
  function automatic logic [7:0] condition_axis(input logic [7:0] v, input logic [6:0] lim);
    logic signed [8:0] v9;
    logic signed [8:0] l9;
    logic signed [8:0] res;
    v9 = $signed({v[7], v});
    l9 = $signed({2'b00, lim});
    if ((v9 >= -DEAD_ZONE) && (v9 <= DEAD_ZONE)) begin
      res = 9'sd0;
    end else if (v9 > l9) begin
      res = l9;
    end else if (v9 < -l9) begin
      res = -l9;
    end else begin
      res = v9;
    end
    return res[7:0];
  endfunction

endpackage
`default_nettype wire

[src/pad_edge_repeat_deadzone_top.sv]
// Top level: pad poll pipeline with edge detect, auto-repeat and stick dead zone.
// Path: input transfer into the read stage (state read), then into the result register.
// Throughput: one poll per cycle while out_ready does not hold the result register, including back-to-back
//   polls of the same pad, set by the read-modify-write of the per-pad state memory with bypass.
// Reset: synchronous active-low; clears pipeline valids and per-pad state valid bits
//   (all pads read as zero buttons and zero counter) and loads register defaults.
`default_nettype none
module pad_edge_repeat_deadzone_top #(
  parameter int NUM_PADS = pedr_pkg::NUM_PADS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_pad_index,
  input  wire logic [7:0]  in_status_code,
  input  wire logic [15:0] in_buttons,
  input  wire logic [7:0]  in_stick_x_in,
  input  wire logic [7:0]  in_stick_y_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_connected,
  output logic [15:0]      out_held,
  output logic [15:0]      out_pressed,
  output logic [15:0]      out_repeat_res,
  output logic [7:0]       out_raw_x,
  output logic [7:0]       out_raw_y,
  output logic [7:0]       out_stick_x,
  output logic [7:0]       out_stick_y
);

  localparam int AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam logic [31:0] NP = 32'(NUM_PADS);

  pedr_pkg::cfg_t       cfg;
  pedr_pkg::pad_entry_t rd_entry;
  pedr_pkg::pad_entry_t wr_entry;

  logic [AW+1:0] pad_ext;
  logic [AW-1:0] in_addr;
  logic          in_pad_ok;
  logic          in_xfer;

  // stage 1: state read in flight
  logic          s1_v_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_pad_ok_r;
  logic [7:0]    s1_status_r;
  logic [15:0]   s1_btn_r;
  logic [7:0]    s1_x_r;
  logic [7:0]    s1_y_r;
  logic          s1_go;

  logic [15:0] prev;
  logic [7:0]  cnt;
  logic [7:0]  dec;
  logic [15:0] pressed;
  logic [15:0] rep;
  logic [7:0]  cnt_nxt;

  logic out_valid_r;

  pedr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign pad_ext   = {{AW{1'b0}}, in_pad_index};
  assign in_addr   = pad_ext[AW-1:0];
  assign in_pad_ok = 32'(in_pad_index) < NP;

  assign s1_go    = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  pedr_state_ram #(
    .DEPTH (NUM_PADS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_addr),
    .rd_data (rd_entry),
    .wr_en   (s1_go && s1_pad_ok_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr_r   <= in_addr;
      s1_pad_ok_r <= in_pad_ok;
      s1_status_r <= in_status_code;
      s1_btn_r    <= in_buttons;
      s1_x_r      <= in_stick_x_in;
      s1_y_r      <= in_stick_y_in;
    end
  end

  // Out-of-range pads evaluate against zero state and write nothing.
  always_comb begin
    prev    = s1_pad_ok_r ? rd_entry.prev_buttons : '0;
    cnt     = s1_pad_ok_r ? rd_entry.count : '0;
    dec     = cnt - 8'd1;
    pressed = s1_btn_r & ~prev;
    if (s1_btn_r != prev) begin
      rep     = pressed;
      cnt_nxt = cfg.initial_delay;
    end else if (dec == 8'd0) begin
      rep     = s1_btn_r;
      cnt_nxt = cfg.repeat_interval;
    end else begin
      rep     = '0;
      cnt_nxt = dec;
    end
    wr_entry.prev_buttons = s1_btn_r;
    wr_entry.count        = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_connected  <= s1_status_r != pedr_pkg::STATUS_NO_RESPONSE;
      out_held       <= s1_btn_r;
      out_pressed    <= pressed;
      out_repeat_res <= rep;
      out_raw_x      <= s1_x_r;
      out_raw_y      <= s1_y_r;
      out_stick_x    <= pedr_pkg::condition_axis(s1_x_r, cfg.x_limit);
      out_stick_y    <= pedr_pkg::condition_axis(s1_y_r, cfg.y_limit);
    end
  end

  assign out_valid = out_valid_r;

  // An empty result register must never block input.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  // Every transfer occupies the read stage on the next cycle.
  a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_v_r)
    else $error("accepted poll lost before read stage");

  // A blocked read stage keeps its item and its read data.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_btn_r) && $stable(rd_entry)))
    else $error("stalled read stage changed");

endmodule
`default_nettype wire

[src/pedr_cfg_regs.sv]
// Configuration registers for limits and repeat timing.
`default_nettype none
module pedr_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_wdata,
  output pedr_pkg::cfg_t        cfg
);

  pedr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_limit         <= pedr_pkg::X_LIMIT_RST;
      cfg_r.y_limit         <= pedr_pkg::Y_LIMIT_RST;
      cfg_r.initial_delay   <= pedr_pkg::INITIAL_DELAY_RST;
      cfg_r.repeat_interval <= pedr_pkg::REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pedr_pkg::CFG_X_LIMIT:         cfg_r.x_limit         <= cfg_wdata[6:0];
        pedr_pkg::CFG_Y_LIMIT:         cfg_r.y_limit         <= cfg_wdata[6:0];
        pedr_pkg::CFG_INITIAL_DELAY:   cfg_r.initial_delay   <= cfg_wdata;
        pedr_pkg::CFG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[src/pedr_state_ram.sv]
// Per-pad state memory: one read, one write port, valid bits and write-to-read bypass.
`default_nettype none
module pedr_state_ram #(
  parameter int DEPTH = pedr_pkg::NUM_PADS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output pedr_pkg::pad_entry_t      rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire pedr_pkg::pad_entry_t wr_data
);

  pedr_pkg::pad_entry_t mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  pedr_pkg::pad_entry_t rd_r;
  pedr_pkg::pad_entry_t byp_r;
  logic                 rd_vld_r;
  logic                 byp_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r  <= mem[rd_addr];
      byp_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        // forward a write that lands on the entry being read
        byp_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp_hit_r) begin
      rd_data = byp_r;
    end else if (rd_vld_r) begin
      rd_data = rd_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for pad_edge_repeat_deadzone_top: directed and random polls checked against a per-pad predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DEAD_BAND      = 9;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [1:0]         pad;
    logic [7:0]         status;
    logic [15:0]        buttons;
    logic signed [7:0]  sx;
    logic signed [7:0]  sy;
  } poll_t;

  typedef struct packed {
    logic        connected;
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] rpt;
    logic [7:0]  raw_x;
    logic [7:0]  raw_y;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
  } pad_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_pad_index;
  logic [7:0]  in_status_code;
  logic [15:0] in_buttons;
  logic [7:0]  in_stick_x_in;
  logic [7:0]  in_stick_y_in;
  logic        out_valid;
  logic        out_ready;
  logic        out_connected;
  logic [15:0] out_held;
  logic [15:0] out_pressed;
  logic [15:0] out_repeat_res;
  logic [7:0]  out_raw_x;
  logic [7:0]  out_raw_y;
  logic [7:0]  out_stick_x;
  logic [7:0]  out_stick_y;

  // Predictor state: registers and per-pad history
  logic [6:0]  x_lim;
  logic [6:0]  y_lim;
  logic [7:0]  delay_load;
  logic [7:0]  interval_load;
  logic [15:0] pad_prev [4];
  logic [7:0]  pad_count [4];

  poll_t       poll_q [$];
  pad_report_t report_q [$];
  logic [15:0] pad_word [4];

  int tx_idle_pct;
  int rx_idle_pct;
  bit tx_pause;
  int hold_req;
  int hold_ack;
  int hold_left;
  int stall_cycles;
  int err_cnt;

  pad_edge_repeat_deadzone_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pad_index   (in_pad_index),
    .in_status_code (in_status_code),
    .in_buttons     (in_buttons),
    .in_stick_x_in  (in_stick_x_in),
    .in_stick_y_in  (in_stick_y_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_connected  (out_connected),
    .out_held       (out_held),
    .out_pressed    (out_pressed),
    .out_repeat_res (out_repeat_res),
    .out_raw_x      (out_raw_x),
    .out_raw_y      (out_raw_y),
    .out_stick_x    (out_stick_x),
    .out_stick_y    (out_stick_y)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Dead band around center, then clamp to +/- lim
  function automatic logic [7:0] shape_axis(logic signed [7:0] v, logic [6:0] lim);
    int iv;
    int il;
    iv = v;
    il = lim;
    if (iv >= -DEAD_BAND && iv <= DEAD_BAND) return 8'd0;
    if (iv > il) return 8'(il);
    if (iv < -il) return 8'(-il);
    return 8'(iv);
  endfunction

  function automatic pad_report_t predict_poll(poll_t p);
    pad_report_t r;
    logic [15:0] last;
    logic [7:0]  cnt;
    last = pad_prev[p.pad];
    cnt = pad_count[p.pad];
    r.connected = (p.status != pedr_pkg::STATUS_NO_RESPONSE);
    r.held = p.buttons;
    r.pressed = p.buttons & ~last;
    if (p.buttons != last) begin
      r.rpt = r.pressed;
      cnt = delay_load;
    end else begin
      // counter at zero wraps to 255 here
      cnt = cnt - 8'd1;
      if (cnt == 8'd0) begin
        r.rpt = p.buttons;
        cnt = interval_load;
      end else begin
        r.rpt = 16'h0000;
      end
    end
    pad_prev[p.pad] = p.buttons;
    pad_count[p.pad] = cnt;
    r.raw_x = p.sx;
    r.raw_y = p.sy;
    r.stick_x = shape_axis(p.sx, x_lim);
    r.stick_y = shape_axis(p.sy, y_lim);
    return r;
  endfunction

  task automatic flag_error(string what, int got, int want);
    if (err_cnt < MAX_PRINTED)
      $display("%0t ERROR %s: got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Driver: present the oldest pending poll, hold it until transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) report_q.push_back(predict_poll(poll_q.pop_front()));
      if (!(in_valid && !in_ready)) begin
        if (poll_q.size() > 0 && !tx_pause && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_pad_index <= poll_q[0].pad;
          in_status_code <= poll_q[0].status;
          in_buttons <= poll_q[0].buttons;
          in_stick_x_in <= poll_q[0].sx;
          in_stick_y_in <= poll_q[0].sy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then pick out_ready
  always @(posedge clk) begin
    pad_report_t got;
    pad_report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_connected, out_held, out_pressed, out_repeat_res,
             out_raw_x, out_raw_y, out_stick_x, out_stick_y};
      if (report_q.size() == 0) begin
        flag_error("result with no poll pending", got.held, 0);
      end else begin
        want = report_q.pop_front();
        if (got.connected !== want.connected) flag_error("connected", got.connected, want.connected);
        if (got.held !== want.held) flag_error("held", got.held, want.held);
        if (got.pressed !== want.pressed) flag_error("pressed", got.pressed, want.pressed);
        if (got.rpt !== want.rpt) flag_error("repeat_res", got.rpt, want.rpt);
        if (got.raw_x !== want.raw_x) flag_error("raw_x", got.raw_x, want.raw_x);
        if (got.raw_y !== want.raw_y) flag_error("raw_y", got.raw_y, want.raw_y);
        if (got.stick_x !== want.stick_x) flag_error("stick_x", got.stick_x, want.stick_x);
        if (got.stick_y !== want.stick_y) flag_error("stick_y", got.stick_y, want.stick_y);
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("pad_edge_repeat_deadzone_top verification failed");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pedr_pkg::CFG_X_LIMIT:         x_lim = val[6:0];
      pedr_pkg::CFG_Y_LIMIT:         y_lim = val[6:0];
      pedr_pkg::CFG_INITIAL_DELAY:   delay_load = val;
      pedr_pkg::CFG_REPEAT_INTERVAL: interval_load = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (poll_q.size() != 0 || in_valid || report_q.size() != 0);
  endtask

  // Drain, let the pipeline settle, load all four registers, set idling
  task automatic start_phase(int tx_pct, int rx_pct, logic [7:0] xl, logic [7:0] yl,
                             logic [7:0] dl, logic [7:0] il);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(pedr_pkg::CFG_X_LIMIT, xl);
    write_reg(pedr_pkg::CFG_Y_LIMIT, yl);
    write_reg(pedr_pkg::CFG_INITIAL_DELAY, dl);
    write_reg(pedr_pkg::CFG_REPEAT_INTERVAL, il);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic push_poll(int pad, int status, int btn, int sx, int sy);
    poll_t p;
    p.pad = 2'(pad);
    p.status = 8'(status);
    p.buttons = 16'(btn);
    p.sx = 8'(sx);
    p.sy = 8'(sy);
    poll_q.push_back(p);
  endtask

  function automatic logic [7:0] rand_axis(logic [6:0] lim);
    int l;
    l = lim;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 255));
      4: begin
        case ($urandom_range(0, 5))
          0: return 8'h80;
          1: return 8'h7F;
          2: return 8'(-DEAD_BAND);
          3: return 8'(DEAD_BAND);
          4: return 8'(-DEAD_BAND - 1);
          default: return 8'(DEAD_BAND + 1);
        endcase
      end
      5: return 8'(l);
      6: return 8'(-l);
      7: return 8'(l + 1);
      8: return 8'(-l - 1);
      default: return 8'($urandom_range(0, 20) - 10);
    endcase
  endfunction

  // Mostly each pad keeps its word so the counters run out; some
  // single-bit changes, some full rewrites, a little noise
  task automatic push_random(int n);
    poll_t p;
    int r;
    for (int k = 0; k < n; k++) begin
      p.pad = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 10) pad_word[p.pad] = 16'($urandom_range(0, 65535));
      else if (r < 22) pad_word[p.pad] ^= 16'(1 << $urandom_range(0, 15));
      else if (r < 25) pad_word[p.pad] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      p.buttons = (r >= 95) ? 16'($urandom_range(0, 65535)) : pad_word[p.pad];
      p.status = ($urandom_range(0, 6) == 0) ? pedr_pkg::STATUS_NO_RESPONSE
                                               : 8'($urandom_range(0, 255));
      p.sx = rand_axis(x_lim);
      p.sy = rand_axis(y_lim);
      poll_q.push_back(p);
    end
  endtask

  // One pad, one word, long enough to outlast a 256-poll counter
  task automatic push_burst(int pad, int n);
    logic [15:0] w;
    w = 16'($urandom_range(1, 65535));
    for (int k = 0; k < n; k++)
      push_poll(pad, $urandom_range(0, 255), w, rand_axis(x_lim), rand_axis(y_lim));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pedr_pkg::CFG_X_LIMIT;
    cfg_wdata = 8'd0;
    in_valid = 1'b0;
    in_pad_index = 2'd0;
    in_status_code = 8'd0;
    in_buttons = 16'd0;
    in_stick_x_in = 8'd0;
    in_stick_y_in = 8'd0;
    out_ready = 1'b0;
    tx_idle_pct = 36;
    rx_idle_pct = 67;
    tx_pause = 1'b0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    stall_cycles = 0;
    err_cnt = 0;
    x_lim = pedr_pkg::X_LIMIT_RST;
    y_lim = pedr_pkg::Y_LIMIT_RST;
    delay_load = pedr_pkg::INITIAL_DELAY_RST;
    interval_load = pedr_pkg::REPEAT_INTERVAL_RST;
    for (int i = 0; i < 4; i++) begin
      pad_prev[i] = 16'h0000;
      pad_count[i] = 8'h00;
      pad_word[i] = 16'h0000;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset register values
    push_poll(0, 8, 16'h0000, 0, 0);          // unchanged word with counter at zero
    push_poll(0, 1, 16'h0000, 0, 0);
    push_poll(1, 0, 16'hFFFF, -128, 127);
    push_poll(1, 255, 16'hFFFF, 127, -128);
    push_poll(1, 7, 16'h0F0F, -9, 9);
    push_poll(1, 9, 16'hFFFF, -10, 10);
    push_poll(2, 8'h80, 16'h8001, 70, -70);
    push_poll(2, 8, 16'h8000, 71, -71);
    push_poll(2, 8'h10, 16'h8000, 69, -69);
    push_poll(3, 8'h55, 16'hAAAA, 1, -1);
    push_poll(3, 8'hAA, 16'h5555, -1, 1);
    push_poll(3, 8, 16'h5555, 10, -10);
    push_poll(0, 8'h7F, 16'h0001, 127, 127);
    push_poll(0, 8'hFE, 16'h0001, -128, -128);

    // Limit extremes, fast repeat
    start_phase(36, 67, 8'd127, 8'd0, 8'd3, 8'd2);
    push_poll(0, 0, 16'h1234, -128, -128);      // -128 against 127, and zero limit
    push_poll(1, 0, 16'h4321, 127, 10);
    push_random(80);

    start_phase(36, 67, 8'd0, 8'd127, 8'd1, 8'd1);
    push_random(80);

    // Zero delay and interval behave as 256 polls
    start_phase(67, 36, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)), 8'd0, 8'd0);
    push_burst($urandom_range(0, 3), 260);
    push_random(60);

    // Limit write with the top bit set; sender pause mid-phase
    start_phase(67, 36, 8'h85, 8'd9, 8'd255, 8'd255);
    push_random(40);
    do @(negedge clk); while (poll_q.size() >= 10);
    tx_pause = 1'b1;
    do @(negedge clk); while (in_valid || report_q.size() != 0);
    tx_pause = 1'b0;
    push_random(40);

    // Long receiver hold-off so the pipe fills and backs up the input
    start_phase(0, 0, 8'd10, 8'd1, 8'd2, 8'd3);
    hold_req++;
    push_random(80);

    start_phase(0, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
    push_random(80);

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("pad_edge_repeat_deadzone_top verification clean");
    end else begin
      $display("pad_edge_repeat_deadzone_top verification failed");
    end
    $finish;
  end

endmodule

[pad_edge_repeat_deadzone_top.f]
src/pedr_pkg.sv
src/pedr_cfg_regs.sv
src/pedr_state_ram.sv
src/pad_edge_repeat_deadzone_top.sv
dv/testbench.sv
